FILE: rtl/core/vcdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vcdp_pkg;

    // sizes
    localparam int MAX_CHANNELS = 8;
    localparam int MAX_SAMPLES  = 1024;
    localparam int LINE_BUFFER  = 96;

    localparam int CHAN_IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHAN_CNT_W   = $clog2(MAX_CHANNELS + 1);
    localparam int SAMPLE_CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int LINE_POS_W   = $clog2(LINE_BUFFER);
    localparam int KW_POS_W     = 4;
    localparam int TOK_CNT_W    = 3;

    // field widths
    localparam int BYTE_W       = 8;
    localparam int TIME_W       = 32;
    localparam int LEVELS_W     = 8;
    localparam int INDEX_W      = 10;
    localparam int M_DATA_W     = 56;

    localparam logic [LINE_POS_W-1:0] LINE_LAST  = LINE_POS_W'(LINE_BUFFER - 1);
    localparam logic [SAMPLE_CNT_W-1:0] SAMPLE_MAX = SAMPLE_CNT_W'(MAX_SAMPLES);
    localparam logic [CHAN_CNT_W-1:0] CHAN_MAX   = CHAN_CNT_W'(MAX_CHANNELS);

    // keyword positions
    localparam logic [KW_POS_W-1:0] KW_POS_FIRST   = 4'd1;
    localparam logic [KW_POS_W-1:0] KW_POS_END_2ND = 4'd2;
    localparam logic [KW_POS_W-1:0] KW_VAR_LEN     = 4'd4;
    localparam logic [KW_POS_W-1:0] KW_END_LEN     = 4'd15;

    // token counts on a $var line
    localparam logic [TOK_CNT_W-1:0] TOK_FIRST = 3'd1;
    localparam logic [TOK_CNT_W-1:0] TOK_ID    = 3'd4;
    localparam logic [TOK_CNT_W-1:0] TOK_SAT   = 3'd5;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_E      = 8'h65;

    // line classes
    typedef enum logic [7:0] {
        LC_START     = 8'b0000_0001,
        LC_KEY_VAR   = 8'b0000_0010,
        LC_VAR_GAP   = 8'b0000_0100,
        LC_VAR_TOKEN = 8'b0000_1000,
        LC_IGNORE    = 8'b0001_0000,
        LC_TIME      = 8'b0010_0000,
        LC_VALUE     = 8'b0100_0000,
        LC_KEY_END   = 8'b1000_0000
    } line_class_t;

    // channel table command from the parser
    typedef struct packed {
        logic                  clear;
        logic                  wr;
        logic [BYTE_W-1:0]     wr_id;
    } chan_cmd_t;

    // channel table lookup answer
    typedef struct packed {
        logic                  hit;
        logic [CHAN_IDX_W-1:0] idx;
    } chan_hit_t;

    // one emitted sample
    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   sample_time;
        logic [LEVELS_W-1:0] sample_levels;
        logic [INDEX_W-1:0]  sample_index;
    } sample_t;

    // characters of "$var" by position
    function automatic logic [7:0] kw_var_char(input logic [KW_POS_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h24;
            4'd1:    ch = 8'h76;
            4'd2:    ch = 8'h61;
            4'd3:    ch = 8'h72;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // characters of "$enddefinitions" by position
    function automatic logic [7:0] kw_end_char(input logic [KW_POS_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h24;
            4'd1:    ch = 8'h65;
            4'd2:    ch = 8'h6e;
            4'd3:    ch = 8'h64;
            4'd4:    ch = 8'h64;
            4'd5:    ch = 8'h65;
            4'd6:    ch = 8'h66;
            4'd7:    ch = 8'h69;
            4'd8:    ch = 8'h6e;
            4'd9:    ch = 8'h69;
            4'd10:   ch = 8'h74;
            4'd11:   ch = 8'h69;
            4'd12:   ch = 8'h6f;
            4'd13:   ch = 8'h6e;
            4'd14:   ch = 8'h73;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/vcdp_chan_table.sv
`timescale 1ns / 1ps
`default_nettype none

module vcdp_chan_table
    import vcdp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire chan_cmd_t         cmd,
    input  wire logic [BYTE_W-1:0] look_id,
    output chan_hit_t              look
);

    logic [BYTE_W-1:0]     ids_reg [MAX_CHANNELS];
    logic [CHAN_CNT_W-1:0] count_reg;
    logic [CHAN_CNT_W-1:0] count_next;
    logic                  wr_ok;

    assign wr_ok = cmd.wr && (count_reg < CHAN_MAX);

    // channel count
    always_comb begin
        count_next = count_reg;
        if (cmd.clear) begin
            count_next = '0;
        end else if (wr_ok) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // id store, written at the next free slot
    always_ff @(posedge aclk) begin
        if (wr_ok && !cmd.clear) begin
            ids_reg[count_reg[CHAN_IDX_W-1:0]] <= cmd.wr_id;
        end
    end

    // lowest recorded channel with a matching id
    always_comb begin
        look.hit = 1'b0;
        look.idx = '0;
        for (int i = MAX_CHANNELS - 1; i >= 0; i--) begin
            if ((CHAN_CNT_W'(i) < count_reg) && (ids_reg[i] == look_id)) begin
                look.hit = 1'b1;
                look.idx = CHAN_IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/vcdp_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module vcdp_parser
    import vcdp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire logic              eof,
    input  wire logic [BYTE_W-1:0] ch,
    input  wire chan_hit_t         look,
    output chan_cmd_t              cmd,
    output sample_t                emit
);

    logic                    in_data_reg,  in_data_next;
    logic [LEVELS_W-1:0]     level_reg,    level_next;
    logic [TIME_W-1:0]       time_reg,     time_next;
    logic                    pending_reg,  pending_next;
    logic [SAMPLE_CNT_W-1:0] scount_reg,   scount_next;
    logic [LINE_POS_W-1:0]   line_pos_reg, line_pos_next;
    line_class_t             class_reg,    class_next;
    logic [KW_POS_W-1:0]     kmp_reg,      kmp_next;
    logic [TOK_CNT_W-1:0]    tok_reg,      tok_next;
    logic [BYTE_W-1:0]       cand_reg,     cand_next;

    logic                    can_emit;
    logic                    var_close;
    logic [TIME_W-1:0]       time_x10;

    assign can_emit  = pending_reg && (scount_reg < SAMPLE_MAX);
    assign var_close = (tok_reg >= TOK_SAT);
    assign time_x10  = (time_reg << 3) + (time_reg << 1);

    // per-item state update
    always_comb begin
        in_data_next  = in_data_reg;
        level_next    = level_reg;
        time_next     = time_reg;
        pending_next  = pending_reg;
        scount_next   = scount_reg;
        line_pos_next = line_pos_reg;
        class_next    = class_reg;
        kmp_next      = kmp_reg;
        tok_next      = tok_reg;
        cand_next     = cand_reg;
        // sample output fields follow the pending state
        emit.sample_time   = time_reg;
        emit.sample_levels = level_reg;
        emit.sample_index  = scount_reg[INDEX_W-1:0];
        emit.valid    = 1'b0;
        cmd.clear     = 1'b0;
        cmd.wr        = 1'b0;
        cmd.wr_id     = cand_reg;

        if (fire) begin
            priority if (eof) begin
                // flush, then back to reset
                emit.valid    = can_emit;
                cmd.clear     = 1'b1;
                in_data_next  = 1'b0;
                level_next    = '0;
                time_next     = '0;
                pending_next  = 1'b0;
                scount_next   = '0;
                line_pos_next = '0;
                class_next    = LC_START;
                kmp_next      = '0;
                tok_next      = '0;
                cand_next     = '0;
            end else if (ch == CH_CR) begin
                // dropped
            end else if (ch == CH_LF) begin
                // end of line, close a $var line
                if (class_reg == LC_VAR_GAP || class_reg == LC_VAR_TOKEN) begin
                    cmd.wr = var_close;
                end
                line_pos_next = '0;
                class_next    = LC_START;
                kmp_next      = '0;
                tok_next      = '0;
                cand_next     = '0;
            end else if (line_pos_reg >= LINE_LAST) begin
                // overlong line
            end else begin
                line_pos_next = line_pos_reg + 1'b1;
                unique case (class_reg)
                    LC_START: begin
                        if (ch == CH_SPACE || ch == CH_TAB) begin
                            // leading blank
                        end else if (!in_data_reg) begin
                            if (ch == CH_DOLLAR) begin
                                class_next = LC_KEY_VAR;
                                kmp_next   = KW_POS_FIRST;
                            end else begin
                                class_next = LC_IGNORE;
                            end
                        end else if (ch == CH_HASH) begin
                            emit.valid   = can_emit;
                            if (can_emit) begin
                                scount_next = scount_reg + 1'b1;
                            end
                            time_next    = '0;
                            pending_next = 1'b1;
                            class_next   = LC_TIME;
                        end else if (ch == CH_ZERO || ch == CH_ONE) begin
                            cand_next  = (ch == CH_ONE) ? 8'd1 : 8'd0;
                            class_next = LC_VALUE;
                        end else begin
                            class_next = LC_IGNORE;
                        end
                    end
                    LC_KEY_VAR: begin
                        if (kmp_reg == KW_POS_FIRST && ch == CH_E) begin
                            class_next = LC_KEY_END;
                            kmp_next   = KW_POS_END_2ND;
                        end else if (kmp_reg < KW_VAR_LEN && ch == kw_var_char(kmp_reg)) begin
                            kmp_next = kmp_reg + 1'b1;
                            if (kmp_reg + 1'b1 == KW_VAR_LEN) begin
                                class_next = LC_VAR_TOKEN;
                                tok_next   = TOK_FIRST;
                            end
                        end else begin
                            class_next = LC_IGNORE;
                        end
                    end
                    LC_KEY_END: begin
                        if (kmp_reg < KW_END_LEN && ch == kw_end_char(kmp_reg)) begin
                            kmp_next = kmp_reg + 1'b1;
                            if (kmp_reg + 1'b1 == KW_END_LEN) begin
                                in_data_next = 1'b1;
                                class_next   = LC_IGNORE;
                            end
                        end else begin
                            class_next = LC_IGNORE;
                        end
                    end
                    LC_VAR_GAP, LC_VAR_TOKEN: begin
                        if (ch == CH_NUL) begin
                            cmd.wr     = var_close;
                            class_next = LC_IGNORE;
                        end else if (ch == CH_SPACE) begin
                            class_next = LC_VAR_GAP;
                        end else if (class_reg == LC_VAR_GAP) begin
                            class_next = LC_VAR_TOKEN;
                            if (tok_reg < TOK_SAT) begin
                                tok_next = tok_reg + 1'b1;
                                if (tok_reg + 1'b1 == TOK_ID) begin
                                    cand_next = ch;
                                end
                            end
                        end
                    end
                    LC_TIME: begin
                        if (ch >= CH_ZERO && ch <= CH_NINE) begin
                            time_next = time_x10 + TIME_W'(ch[3:0]);
                        end else begin
                            class_next = LC_IGNORE;
                        end
                    end
                    LC_VALUE: begin
                        if (ch != CH_NUL && look.hit) begin
                            level_next[look.idx] = (cand_reg != '0);
                        end
                        class_next = LC_IGNORE;
                    end
                    LC_IGNORE: begin
                    end
                    default: begin
                        class_next = LC_IGNORE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_data_reg  <= 1'b0;
            level_reg    <= '0;
            time_reg     <= '0;
            pending_reg  <= 1'b0;
            scount_reg   <= '0;
            line_pos_reg <= '0;
            class_reg    <= LC_START;
            kmp_reg      <= '0;
            tok_reg      <= '0;
            cand_reg     <= '0;
        end else begin
            in_data_reg  <= in_data_next;
            level_reg    <= level_next;
            time_reg     <= time_next;
            pending_reg  <= pending_next;
            scount_reg   <= scount_next;
            line_pos_reg <= line_pos_next;
            class_reg    <= class_next;
            kmp_reg      <= kmp_next;
            tok_reg      <= tok_next;
            cand_reg     <= cand_next;
        end
    end

    // end of file leaves the parser in its reset state
    a_eof_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && eof) |=> (scount_reg == '0 && !pending_reg && !in_data_reg
                           && class_reg == LC_START))
        else $error("end of file did not clear parser state");

    // no sample beyond the capture limit
    a_emit_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid |-> (pending_reg && scount_reg < SAMPLE_MAX))
        else $error("sample emitted past limit or without pending sample");

    // a newline restarts the line
    a_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !eof && ch == CH_LF) |=> (line_pos_reg == '0 && class_reg == LC_START
                                          && tok_reg == '0))
        else $error("newline did not restart line");

    // kept line bytes stay within the buffer
    a_line_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        line_pos_reg <= LINE_LAST)
        else $error("line position past buffer");

endmodule

`default_nettype wire

FILE: rtl/core/vcd_value_change_parser.sv
// An accepted item is registered in the input register and parsed from there, and a sample it
// releases is registered in the result register and shows on m_tvalid; m_tready holding off stalls parsing
// throughput: one item per cycle while no sample waits on m_tready; the parser updates its state
// once per item, and the input register takes one more item while a sample waits
// reset: aresetn low (synchronous) clears all control state, header mode, no channels
`timescale 1ns / 1ps
`default_nettype none

module vcd_value_change_parser
    import vcdp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [BYTE_W-1:0]   s_tdata,   // [7:0] char_byte
    input  wire logic                s_tuser,   // [0] op (end of file)
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata    // [31:0] sample_time, [39:32] sample_levels,
                                                // [49:40] sample_index, [55:50] zero
);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eof_reg;
    logic              out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic              proc_fire;
    logic              s_fire;
    chan_cmd_t         cmd;
    chan_hit_t         look;
    sample_t           emit;

    // parse when an item is held and the result register can take a sample
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_eof_reg  <= s_tuser;
        end
    end

    vcdp_chan_table u_chan_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .look_id (in_byte_reg),
        .look    (look)
    );

    vcdp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (proc_fire),
        .eof     (in_eof_reg),
        .ch      (in_byte_reg),
        .look    (look),
        .cmd     (cmd),
        .emit    (emit)
    );

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit.valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            out_data_reg <= {(M_DATA_W - TIME_W - LEVELS_W - INDEX_W)'(0),
                             emit.sample_index, emit.sample_levels, emit.sample_time};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: verif/vcd_value_change_parser_tb.sv
`timescale 1ns / 1ps

module vcd_value_change_parser_tb;
    import vcdp_pkg::*;

    localparam int RUN_LIMIT    = 600000;
    localparam int PHASE_ITEMS  = 400;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [BYTE_W-1:0]   s_tdata  = '0;     // [7:0] char_byte
    logic                s_tuser  = 1'b0;   // [0] op (end of file)
    logic                s_tready;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;           // [31:0] time, [39:32] levels, [49:40] index

    // tracks the parser state and holds the samples still to come out
    class sample_scoreboard;
        typedef struct {
            logic [TIME_W-1:0]   stamp;
            logic [LEVELS_W-1:0] levels;
            logic [INDEX_W-1:0]  index;
        } due_sample_t;

        due_sample_t samples_due[$];
        int          errors;
        string       var_word;
        string       end_word;
        bit          data_mode;
        logic [7:0]  ids[MAX_CHANNELS];
        int          n_chan;
        logic [7:0]  levels;
        logic [31:0] cur_time;
        bit          pending;
        int          n_samples;
        int          line_pos;
        line_class_t cls;
        int          kw_pos;
        int          tokens;
        logic [7:0]  cand;

        function new();
            errors   = 0;
            var_word = "$var";
            end_word = "$enddefinitions";
            clear_all();
        endfunction

        function void start_line();
            line_pos = 0;
            cls      = LC_START;
            kw_pos   = 0;
            tokens   = 0;
            cand     = 8'h00;
        endfunction

        function void clear_all();
            data_mode = 1'b0;
            foreach (ids[i]) ids[i] = 8'h00;
            n_chan    = 0;
            levels    = 8'h00;
            cur_time  = 32'h0;
            pending   = 1'b0;
            n_samples = 0;
            start_line();
        endfunction

        function void close_var();
            if (tokens >= 5 && n_chan < MAX_CHANNELS) begin
                ids[n_chan] = cand;
                n_chan++;
            end
        endfunction

        function void release_sample();
            due_sample_t s;
            if (pending && n_samples < MAX_SAMPLES) begin
                s.stamp  = cur_time;
                s.levels = levels;
                s.index  = INDEX_W'(n_samples);
                samples_due.push_back(s);
                n_samples++;
            end
        endfunction

        function int due_count();
            return samples_due.size();
        endfunction

        // one accepted input item
        function void take_byte(bit op, logic [7:0] c);
            if (op) begin
                release_sample();
                clear_all();
                return;
            end
            if (c == CH_CR)
                return;
            if (c == CH_LF) begin
                if (cls == LC_VAR_GAP || cls == LC_VAR_TOKEN)
                    close_var();
                start_line();
                return;
            end
            // bytes past the line buffer are dropped
            if (line_pos >= LINE_BUFFER - 1)
                return;
            line_pos++;

            case (cls)
                LC_START: begin
                    if (c != CH_SPACE && c != CH_TAB) begin
                        if (!data_mode) begin
                            if (c == CH_DOLLAR) begin
                                cls    = LC_KEY_VAR;
                                kw_pos = 1;
                            end else begin
                                cls = LC_IGNORE;
                            end
                        end else if (c == CH_HASH) begin
                            release_sample();
                            cur_time = 32'h0;
                            pending  = 1'b1;
                            cls      = LC_TIME;
                        end else if (c == CH_ZERO || c == CH_ONE) begin
                            cand = (c == CH_ONE) ? 8'd1 : 8'd0;
                            cls  = LC_VALUE;
                        end else begin
                            cls = LC_IGNORE;
                        end
                    end
                end
                LC_KEY_VAR: begin
                    if (kw_pos == 1 && c == CH_E) begin
                        cls    = LC_KEY_END;
                        kw_pos = 2;
                    end else if (kw_pos < 4 && c == var_word[kw_pos]) begin
                        kw_pos++;
                        if (kw_pos == 4) begin
                            cls    = LC_VAR_TOKEN;
                            tokens = 1;
                        end
                    end else begin
                        cls = LC_IGNORE;
                    end
                end
                LC_KEY_END: begin
                    if (kw_pos < 15 && c == end_word[kw_pos]) begin
                        kw_pos++;
                        if (kw_pos == 15) begin
                            data_mode = 1'b1;
                            cls       = LC_IGNORE;
                        end
                    end else begin
                        cls = LC_IGNORE;
                    end
                end
                LC_VAR_GAP, LC_VAR_TOKEN: begin
                    // tabs belong to tokens, only spaces separate
                    if (c == CH_NUL) begin
                        close_var();
                        cls = LC_IGNORE;
                    end else if (c == CH_SPACE) begin
                        cls = LC_VAR_GAP;
                    end else if (cls == LC_VAR_GAP) begin
                        cls = LC_VAR_TOKEN;
                        if (tokens < 5) begin
                            tokens++;
                            if (tokens == 4)
                                cand = c;
                        end
                    end
                end
                LC_TIME: begin
                    if (c >= CH_ZERO && c <= CH_NINE)
                        cur_time = cur_time * 32'd10 + 32'(c - CH_ZERO);
                    else
                        cls = LC_IGNORE;
                end
                LC_VALUE: begin
                    // lowest channel with a matching id wins
                    if (c != CH_NUL) begin
                        for (int i = 0; i < n_chan; i++) begin
                            if (ids[i] == c) begin
                                levels[i] = (cand != 8'd0);
                                break;
                            end
                        end
                    end
                    cls = LC_IGNORE;
                end
                default: begin
                end
            endcase
        endfunction

        // one accepted result item
        function void check_sample(logic [M_DATA_W-1:0] d);
            due_sample_t s;
            if (samples_due.size() == 0) begin
                $display("%0t: unexpected sample %h", $time, d);
                errors++;
                return;
            end
            s = samples_due.pop_front();
            if (d[31:0] !== s.stamp) begin
                $display("%0t: sample_time expected %0d actual %0d", $time, s.stamp, d[31:0]);
                errors++;
            end
            if (d[39:32] !== s.levels) begin
                $display("%0t: sample_levels expected %h actual %h", $time, s.levels,
                         d[39:32]);
                errors++;
            end
            if (d[49:40] !== s.index) begin
                $display("%0t: sample_index expected %0d actual %0d", $time, s.index,
                         d[49:40]);
                errors++;
            end
            if (d[55:50] !== 6'd0) begin
                $display("%0t: tdata padding expected 0 actual %h", $time, d[55:50]);
                errors++;
            end
        endfunction
    endclass

    sample_scoreboard sb = new();

    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    int         phase        = 0;
    int         bytes_sent   = 0;
    int         cycles       = 0;
    int         hold_left    = 0;
    bit         hold_done    = 1'b0;
    logic [7:0] id_pool[6];

    initial begin
        forever #5 aclk = ~aclk;
    end

    vcd_value_change_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_sample(m_tdata);
    end

    // receiver, with one long hold-off in the last phase
    always @(negedge aclk) begin
        if (!hold_done && phase == 3) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog
    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= RUN_LIMIT) begin
                $display("[vcd_value_change_parser] ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(input bit op, input logic [7:0] ch);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.take_byte(op, ch);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, s[i]);
    endtask

    task automatic end_line();
        if ($urandom_range(7) == 0)
            send_item(1'b0, CH_CR);
        send_item(1'b0, CH_LF);
    endtask

    task automatic send_eof();
        send_item(1'b1, 8'($urandom_range(255)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12))
            send_item(1'b0, 8'($urandom_range(255)));
    endtask

    function automatic string rand_digits(input int n);
        string s;
        s = "";
        repeat (n)
            s = {s, $sformatf("%0d", $urandom_range(9))};
        return s;
    endfunction

    function automatic string time_text();
        case ($urandom_range(4))
            0:       return $sformatf("%0d", $urandom_range(999));
            1:       return $sformatf("%0d", $urandom);
            2:       return "4294967295";
            3:       return "0";
            default: return rand_digits($urandom_range(10, 14));
        endcase
    endfunction

    function automatic logic [7:0] pick_id();
        return id_pool[$urandom_range(5)];
    endfunction

    // one dump: header, variable definitions, usually a definitions end, value changes, usually an end of file
    task automatic gen_file();
        int         n_var;
        int         n_dat;
        int         pick;
        logic [7:0] id;
        string      idc;
        foreach (id_pool[i]) id_pool[i] = 8'($urandom_range(33, 126));

        repeat ($urandom_range(0, 2)) begin
            pick = $urandom_range(3);
            if (pick == 0)
                send_text("$timescale 1ns $end");
            else if (pick == 1)
                send_text(" $scope module top $end");
            else if (pick == 2)
                send_text("$version x $end");
            else
                send_noise();
            end_line();
        end

        // variable definitions, sometimes more than the table holds
        n_var = ($urandom_range(3) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 8);
        repeat (n_var) begin
            id  = pick_id();
            idc = $sformatf("%c", id);
            case ($urandom_range(11))
                6:  send_text({"$var wire 1 ", idc});
                7:  send_text({"$var\twire  1 x ", idc, " z"});
                8: begin
                    send_text({"$var wire 1 ", idc, " s"});
                    send_item(1'b0, CH_NUL);
                    send_text(" t u");
                end
                9: begin
                    send_text("$var w 1");
                    send_item(1'b0, CH_NUL);
                    send_text({" ", idc, " q r"});
                end
                10: send_text({"$variable a b ", idc, " c"});
                11: begin
                    if ($urandom_range(1))
                        send_text({"$var wire 1 ", idc, " ", rand_digits(90), " $end"});
                    else
                        send_text({"$var ", rand_digits(95), " 1 ", idc, " n"});
                end
                default: begin
                    if ($urandom_range(2) == 0)
                        send_text(" \t");
                    send_text({"$var wire 1 ", idc, " sig $end"});
                end
            endcase
            end_line();
        end

        pick = $urandom_range(15);
        if (pick == 1 || pick == 2) begin
            send_text("$enddef $end");
            end_line();
            send_text("\t$enddefinitionsX");
            end_line();
        end else if (pick != 0) begin
            send_text("$enddefinitions $end");
            end_line();
        end

        // value change section
        n_dat = $urandom_range(0, 30);
        for (int k = 0; k < n_dat; k++) begin
            pick = $urandom_range(15);
            if (pick <= 4) begin
                send_text({"#", time_text()});
            end else if (pick <= 10) begin
                if ($urandom_range(3) == 0)
                    send_text("  ");
                send_item(1'b0, $urandom_range(1) ? CH_ONE : CH_ZERO);
                send_item(1'b0, ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : pick_id());
            end else if (pick == 11) begin
                send_text("#12");
                send_item(1'b0, $urandom_range(1) ? CH_NUL : 8'h61);
                send_text("99");
            end else if (pick == 12) begin
                send_noise();
            end else if (pick == 13) begin
                send_item(1'b0, CH_ONE);
                if ($urandom_range(1))
                    send_item(1'b0, CH_NUL);
            end else if (pick == 14) begin
                send_text({"#", rand_digits(100)});
            end else begin
                send_text("$dumpvars");
            end
            // a dump may stop in the middle of a line
            if (k != n_dat - 1 || $urandom_range(5) != 0)
                end_line();
        end
        if ($urandom_range(19) != 0)
            send_eof();
    endtask

    // more time marks than the sample store takes
    task automatic overflow_file();
        send_text("$var wire 1 ! clk $end");
        end_line();
        send_text("$enddefinitions $end");
        end_line();
        send_text("1!");
        end_line();
        for (int k = 0; k < MAX_SAMPLES + 6; k++) begin
            send_text("#");
            if (k % 128 == 0)
                send_text("7");
            end_line();
            if (k == 500) begin
                send_text("0!");
                end_line();
            end
        end
        send_eof();
    endtask

    task automatic random_phase();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_ITEMS)
            gen_file();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        phase        = 1;
        src_idle_pct = 21;
        snk_idle_pct = 88;
        // end of file in header mode, keyword with a suffix, empty time
        send_item(1'b1, 8'hff);
        send_text("$enddefinitionsX");
        send_item(1'b0, CH_CR);
        send_item(1'b0, CH_LF);
        send_text("#");
        send_item(1'b0, CH_NUL);
        send_item(1'b0, CH_LF);
        send_eof();
        random_phase();

        phase        = 2;
        src_idle_pct = 88;
        snk_idle_pct = 21;
        random_phase();

        phase        = 3;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        overflow_file();
        random_phase();

        s_tvalid <= 1'b0;
        while (sb.due_count() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("[vcd_value_change_parser] OK");
        else
            $display("[vcd_value_change_parser] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/vcdp_pkg.sv
rtl/core/vcdp_chan_table.sv
rtl/core/vcdp_parser.sv
rtl/core/vcd_value_change_parser.sv
verif/vcd_value_change_parser_tb.sv
